// ----- rtl/core/first_fit_heap_allocator_core_assert.svh -----
// ----------------------------------------------------------------------------
// First-fit heap allocator assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTH
`define FFHA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FFHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FFHA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define FFHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/core/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// Types, constants and helpers shared by the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int MAX_CHUNKS     = 256;
    localparam int HEADER_BYTES   = 16;
    localparam int IDX_W          = $clog2(MAX_CHUNKS);
    localparam int LINK_W         = IDX_W + 1;
    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(MAX_CHUNKS);
    localparam logic [31:0] HEAP_BYTES_RST  = 32'd33554432;

    localparam int SPARE_LANES  = 8;
    localparam int SPARE_GROUPS = (MAX_CHUNKS + SPARE_LANES - 1) / SPARE_LANES;
    localparam int GRP_W        = (SPARE_GROUPS > 1) ? $clog2(SPARE_GROUPS) : 1;

    localparam logic CFG_HEAP_BASE  = 1'b0;
    localparam logic CFG_HEAP_BYTES = 1'b1;

    typedef struct packed {
        logic [31:0]       offset;
        logic [31:0]       nbytes;
        logic              in_use;
        logic [LINK_W-1:0] link;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REALLOC = 2'd2,
        OP_CALLOC  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NULL     = 2'd1,
        ST_NO_SPACE = 2'd2,
        ST_BAD_PTR  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        FILL_NONE  = 2'd0,
        FILL_COPY  = 2'd1,
        FILL_CLEAR = 2'd2
    } t_fill;

    typedef enum logic [1:0] {
        J_FREE, J_ALLOC, J_CALLOC, J_REALLOC
    } t_job;

    typedef enum logic [1:0] {
        W_FIND, W_GRANT, W_PROBE
    } t_walk;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_MUL, S_CHK, S_WALK, S_NEXT, S_REL1, S_REL2,
        S_RDONE, S_SPARE, S_GWR, S_DONE
    } t_state;

    typedef struct packed {
        logic             init;
        logic             set_v;
        logic [IDX_W-1:0] set_idx;
        logic             clr_v;
        logic [IDX_W-1:0] clr_idx;
        logic             scan_start;
    } t_busy_cmd;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_busy_sts;

    function automatic logic [31:0] payload_of(input logic [31:0] b);
        return (b < 32'(HEADER_BYTES)) ? 32'd0 : b - 32'(HEADER_BYTES);
    endfunction

endpackage

// ----- rtl/core/ffha_ram.sv -----
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/ffha_busy_map.sv -----
// ----------------------------------------------------------------------------
// ffha_busy_map
// Record busy flags and a spare-record scan, eight records per cycle.
// ----------------------------------------------------------------------------
module ffha_busy_map (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ffha_pkg::t_busy_cmd   i_cmd,
    output ffha_pkg::t_busy_sts   o_sts
);

    logic [ffha_pkg::MAX_CHUNKS-1:0] r_busy, n_busy;
    logic [ffha_pkg::GRP_W-1:0]      r_grp, n_grp;
    logic                            r_scan_on, n_scan_on;
    logic                            hit;
    logic [ffha_pkg::IDX_W-1:0]      hit_idx;
    logic                            last_grp;

    always_comb begin
        int lin;
        hit     = 1'b0;
        hit_idx = '0;
        lin     = 0;
        for (int k = ffha_pkg::SPARE_LANES - 1; k >= 0; k--) begin
            lin = int'(r_grp) * ffha_pkg::SPARE_LANES + k;
            if (lin > 0 && lin < ffha_pkg::MAX_CHUNKS &&
                !r_busy[lin[ffha_pkg::IDX_W-1:0]]) begin
                hit     = 1'b1;
                hit_idx = lin[ffha_pkg::IDX_W-1:0];
            end
        end
    end

    assign last_grp = (r_grp == ffha_pkg::GRP_W'(ffha_pkg::SPARE_GROUPS - 1));

    always_comb begin
        n_busy    = r_busy;
        n_grp     = r_grp;
        n_scan_on = r_scan_on;
        if (r_scan_on) begin
            if (hit || last_grp) begin
                n_scan_on = 1'b0;
            end else begin
                n_grp = r_grp + 1'b1;
            end
        end
        if (i_cmd.scan_start) begin
            n_scan_on = 1'b1;
            n_grp     = '0;
        end
        if (i_cmd.clr_v) begin
            n_busy[i_cmd.clr_idx] = 1'b0;
        end
        if (i_cmd.set_v) begin
            n_busy[i_cmd.set_idx] = 1'b1;
        end
        if (i_cmd.init) begin
            n_busy    = '0;
            n_busy[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= ffha_pkg::MAX_CHUNKS'(1);
            r_grp     <= '0;
            r_scan_on <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_grp     <= n_grp;
            r_scan_on <= n_scan_on;
        end
    end

    assign o_sts.done  = r_scan_on && (hit || last_grp);
    assign o_sts.found = r_scan_on && hit;
    assign o_sts.idx   = hit_idx;

endmodule

// ----- rtl/core/first_fit_heap_allocator_core.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit heap allocator with coalescing over a linked table of chunks.
// ----------------------------------------------------------------------------
// Requests enter on s_axis: tuser carries the operation, tdata the size,
// element count and block address. One response per request leaves on
// m_axis with the granted address, status, fill action and fill length.
// Chunk records live in one RAM, read one per cycle while walking the chain
// in address order; spare records are found by a busy-flag scan of eight
// records per cycle.
// Alloc and calloc walk the chain once (calloc first forms the product and
// checks it against the heap size), plus a spare-record scan when a chunk is
// split. Free walks to the chunk. Realloc walks to the chunk, may walk the
// chain again to check for space, then walks for the new grant.
// One request is in work at a time; the next is taken as soon as the response
// sits in the output register, even if the receiver has not taken it.
// Reset and any configuration write rebuild the table: record 0
// becomes the whole heap. A stalled receiver holds the response and the
// request after it waits in its final state.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,  // request_size, element_count, block_address
    input  logic [1:0]   s_axis_tuser,  // operation
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata,  // result_address, status, fill_action, fill_length
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_wdata
);

    `include "first_fit_heap_allocator_core_assert.svh"

    localparam int IW = ffha_pkg::IDX_W;
    localparam int LW = ffha_pkg::LINK_W;

    ffha_pkg::t_state  r_st, n_st;
    ffha_pkg::t_job    r_job, n_job;
    ffha_pkg::t_walk   r_mode, n_mode;
    logic [31:0]       r_heap_base, n_heap_base;
    logic [31:0]       r_heap_bytes, n_heap_bytes;
    logic [31:0]       r_size, n_size;
    logic [31:0]       r_count, n_count;
    logic [31:0]       r_addr, n_addr;
    logic [31:0]       r_tgt_off, n_tgt_off;
    logic [31:0]       r_need, n_need;
    logic [63:0]       r_mul, n_mul;
    logic [IW-1:0]     r_cur, n_cur;
    logic              r_prev_v, n_prev_v;
    logic [IW-1:0]     r_prev_idx, n_prev_idx;
    ffha_pkg::t_rec    r_prev, n_prev;
    logic [IW-1:0]     r_rec_idx, n_rec_idx;
    ffha_pkg::t_rec    r_rec, n_rec;
    logic              r_nx_v, n_nx_v;
    ffha_pkg::t_rec    r_nx, n_nx;
    logic [31:0]       r_merge_bytes, n_merge_bytes;
    logic [LW-1:0]     r_merge_link, n_merge_link;
    logic [31:0]       r_oldpay, n_oldpay;
    logic              r_split, n_split;
    logic [IW-1:0]     r_spare_idx, n_spare_idx;
    logic [31:0]       r_res_addr, n_res_addr;
    ffha_pkg::t_status r_status, n_status;
    ffha_pkg::t_fill   r_fill, n_fill;
    logic [31:0]       r_len, n_len;
    logic              r_out_valid, n_out_valid;
    logic [31:0]       r_out_addr, n_out_addr;
    ffha_pkg::t_status r_out_status, n_out_status;
    ffha_pkg::t_fill   r_out_fill, n_out_fill;
    logic [31:0]       r_out_len, n_out_len;

    logic                        ram_we;
    logic [IW-1:0]               ram_waddr;
    ffha_pkg::t_rec              ram_wrec;
    logic [IW-1:0]               ram_raddr;
    logic [ffha_pkg::REC_W-1:0]  ram_rdata;
    ffha_pkg::t_rec              q;
    ffha_pkg::t_busy_cmd         busy_cmd;
    ffha_pkg::t_busy_sts         busy_sts;

    assign q = ffha_pkg::t_rec'(ram_rdata);

    ffha_ram #(
        .WIDTH (ffha_pkg::REC_W),
        .DEPTH (ffha_pkg::MAX_CHUNKS)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ffha_pkg::REC_W'(ram_wrec)),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ffha_busy_map u_busy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (busy_cmd),
        .o_sts   (busy_sts)
    );

    always_comb begin
        ffha_pkg::t_op op;
        logic [31:0]   in_size;
        logic [31:0]   in_count;
        logic [31:0]   in_addr;
        logic          fit;
        logic          nxm;
        logic          pm;
        logic [33:0]   merged;
        logic [31:0]   bytes_r;
        logic [LW-1:0] link_r;
        logic [31:0]   rec_pay;
        logic [31:0]   newpay;
        logic [31:0]   gaddr;

        op       = ffha_pkg::t_op'(s_axis_tuser);
        in_size  = s_axis_tdata[31:0];
        in_count = s_axis_tdata[63:32];
        in_addr  = s_axis_tdata[95:64];
        fit      = 1'b0;
        nxm      = 1'b0;
        pm       = 1'b0;
        merged   = '0;
        bytes_r  = '0;
        link_r   = '0;
        rec_pay  = ffha_pkg::payload_of(r_rec.nbytes);
        newpay   = '0;
        gaddr    = r_heap_base + r_rec.offset + 32'(ffha_pkg::HEADER_BYTES);

        n_st = r_st;            n_job = r_job;          n_mode = r_mode;
        n_heap_base = r_heap_base;  n_heap_bytes = r_heap_bytes;
        n_size = r_size;        n_count = r_count;      n_addr = r_addr;
        n_tgt_off = r_tgt_off;  n_need = r_need;        n_mul = r_mul;
        n_cur = r_cur;          n_prev_v = r_prev_v;    n_prev_idx = r_prev_idx;
        n_prev = r_prev;        n_rec_idx = r_rec_idx;  n_rec = r_rec;
        n_nx_v = r_nx_v;        n_nx = r_nx;
        n_merge_bytes = r_merge_bytes;  n_merge_link = r_merge_link;
        n_oldpay = r_oldpay;    n_split = r_split;      n_spare_idx = r_spare_idx;
        n_res_addr = r_res_addr;  n_status = r_status;  n_fill = r_fill;
        n_len = r_len;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_addr = r_out_addr;  n_out_status = r_out_status;
        n_out_fill = r_out_fill;  n_out_len = r_out_len;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wrec  = '0;
        ram_raddr = '0;
        busy_cmd  = '0;
        s_axis_tready = 1'b0;

        unique case (r_st)
            ffha_pkg::S_INIT: begin
                ram_we          = 1'b1;
                ram_wrec.nbytes = r_heap_bytes;
                ram_wrec.link   = ffha_pkg::LINK_NONE;
                busy_cmd.init   = 1'b1;
                n_st            = ffha_pkg::S_IDLE;
            end
            ffha_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_size     = in_size;
                    n_count    = in_count;
                    n_addr     = in_addr;
                    n_tgt_off  = in_addr - r_heap_base - 32'(ffha_pkg::HEADER_BYTES);
                    n_need     = in_size;
                    n_res_addr = '0;
                    n_status   = ffha_pkg::ST_OK;
                    n_fill     = ffha_pkg::FILL_NONE;
                    n_len      = '0;
                    n_cur      = '0;
                    n_prev_v   = 1'b0;
                    n_st       = ffha_pkg::S_WALK;
                    if (op == ffha_pkg::OP_FREE ||
                        (op == ffha_pkg::OP_REALLOC && in_addr != 0 && in_size == 0)) begin
                        n_job  = ffha_pkg::J_FREE;
                        n_mode = ffha_pkg::W_FIND;
                        if (in_addr == 0) begin
                            n_status = ffha_pkg::ST_NULL;
                            n_st     = ffha_pkg::S_DONE;
                        end
                    end else if (op == ffha_pkg::OP_ALLOC || op == ffha_pkg::OP_REALLOC &&
                                 in_addr == 0) begin
                        n_job  = ffha_pkg::J_ALLOC;
                        n_mode = ffha_pkg::W_GRANT;
                        if (in_size == 0) begin
                            n_status = ffha_pkg::ST_NULL;
                            n_st     = ffha_pkg::S_DONE;
                        end
                    end else if (op == ffha_pkg::OP_CALLOC) begin
                        n_job = ffha_pkg::J_CALLOC;
                        n_st  = ffha_pkg::S_MUL;
                        if (in_size == 0 || in_count == 0) begin
                            n_status = ffha_pkg::ST_NULL;
                            n_st     = ffha_pkg::S_DONE;
                        end
                    end else begin
                        n_job  = ffha_pkg::J_REALLOC;
                        n_mode = ffha_pkg::W_FIND;
                    end
                end
            end
            ffha_pkg::S_MUL: begin
                n_mul = 64'(r_size) * 64'(r_count);
                n_st  = ffha_pkg::S_CHK;
            end
            ffha_pkg::S_CHK: begin
                if (r_mul > {32'd0, r_heap_bytes}) begin
                    n_status = ffha_pkg::ST_NO_SPACE;
                    n_st     = ffha_pkg::S_DONE;
                end else begin
                    n_need = r_mul[31:0];
                    n_mode = ffha_pkg::W_GRANT;
                    n_cur  = '0;
                    n_st   = ffha_pkg::S_WALK;
                end
            end
            ffha_pkg::S_WALK: begin
                if (r_mode == ffha_pkg::W_FIND) begin
                    if (q.offset == r_tgt_off) begin
                        n_rec_idx = r_cur;
                        n_rec     = q;
                        n_nx_v    = (q.link != ffha_pkg::LINK_NONE);
                        ram_raddr = q.link[IW-1:0];
                        n_st      = ffha_pkg::S_NEXT;
                    end else if (q.link == ffha_pkg::LINK_NONE) begin
                        n_status = ffha_pkg::ST_BAD_PTR;
                        n_st     = ffha_pkg::S_DONE;
                    end else begin
                        n_prev_v   = 1'b1;
                        n_prev_idx = r_cur;
                        n_prev     = q;
                        n_cur      = q.link[IW-1:0];
                        ram_raddr  = q.link[IW-1:0];
                    end
                end else begin
                    fit = !q.in_use && (ffha_pkg::payload_of(q.nbytes) >= r_need);
                    if (fit) begin
                        if (r_mode == ffha_pkg::W_PROBE) begin
                            n_st = ffha_pkg::S_REL1;
                        end else begin
                            n_rec_idx = r_cur;
                            n_rec     = q;
                            if (ffha_pkg::payload_of(q.nbytes) - r_need >
                                32'(ffha_pkg::HEADER_BYTES)) begin
                                busy_cmd.scan_start = 1'b1;
                                n_st = ffha_pkg::S_SPARE;
                            end else begin
                                n_split = 1'b0;
                                n_st    = ffha_pkg::S_GWR;
                            end
                        end
                    end else if (q.link == ffha_pkg::LINK_NONE) begin
                        n_status = ffha_pkg::ST_NO_SPACE;
                        n_st     = ffha_pkg::S_DONE;
                    end else begin
                        n_cur     = q.link[IW-1:0];
                        ram_raddr = q.link[IW-1:0];
                    end
                end
            end
            ffha_pkg::S_NEXT: begin
                n_nx   = q;
                nxm    = r_nx_v && !q.in_use;
                pm     = r_prev_v && !r_prev.in_use;
                merged = 34'(r_rec.nbytes) + (nxm ? 34'(q.nbytes) : 34'd0) +
                         (pm ? 34'(r_prev.nbytes) : 34'd0);
                if (r_job == ffha_pkg::J_FREE ||
                    (merged >= 34'(ffha_pkg::HEADER_BYTES) &&
                     merged - 34'(ffha_pkg::HEADER_BYTES) >= 34'(r_size))) begin
                    n_st = ffha_pkg::S_REL1;
                end else begin
                    n_mode = ffha_pkg::W_PROBE;
                    n_cur  = '0;
                    n_st   = ffha_pkg::S_WALK;
                end
            end
            ffha_pkg::S_REL1: begin
                nxm     = r_nx_v && !r_nx.in_use;
                pm      = r_prev_v && !r_prev.in_use;
                bytes_r = r_rec.nbytes + (nxm ? r_nx.nbytes : 32'd0);
                link_r  = nxm ? r_nx.link : r_rec.link;
                ram_we          = 1'b1;
                ram_waddr       = r_rec_idx;
                ram_wrec.offset = r_rec.offset;
                ram_wrec.nbytes = bytes_r;
                ram_wrec.link   = link_r;
                busy_cmd.clr_v   = nxm;
                busy_cmd.clr_idx = r_rec.link[IW-1:0];
                n_merge_bytes = bytes_r;
                n_merge_link  = link_r;
                n_oldpay      = rec_pay;
                n_st          = pm ? ffha_pkg::S_REL2 : ffha_pkg::S_RDONE;
            end
            ffha_pkg::S_REL2: begin
                ram_we          = 1'b1;
                ram_waddr       = r_prev_idx;
                ram_wrec.offset = r_prev.offset;
                ram_wrec.nbytes = r_prev.nbytes + r_merge_bytes;
                ram_wrec.link   = r_merge_link;
                busy_cmd.clr_v   = 1'b1;
                busy_cmd.clr_idx = r_rec_idx;
                n_st = ffha_pkg::S_RDONE;
            end
            ffha_pkg::S_RDONE: begin
                if (r_job == ffha_pkg::J_FREE) begin
                    n_st = ffha_pkg::S_DONE;
                end else begin
                    n_mode = ffha_pkg::W_GRANT;
                    n_need = r_size;
                    n_cur  = '0;
                    n_st   = ffha_pkg::S_WALK;
                end
            end
            ffha_pkg::S_SPARE: begin
                if (busy_sts.done) begin
                    n_split     = busy_sts.found;
                    n_spare_idx = busy_sts.idx;
                    if (busy_sts.found) begin
                        ram_we          = 1'b1;
                        ram_waddr       = busy_sts.idx;
                        ram_wrec.offset = r_rec.offset + 32'(ffha_pkg::HEADER_BYTES) + r_need;
                        ram_wrec.nbytes = rec_pay - r_need;
                        ram_wrec.link   = r_rec.link;
                        busy_cmd.set_v   = 1'b1;
                        busy_cmd.set_idx = busy_sts.idx;
                    end
                    n_st = ffha_pkg::S_GWR;
                end
            end
            ffha_pkg::S_GWR: begin
                ram_we          = 1'b1;
                ram_waddr       = r_rec_idx;
                ram_wrec.offset = r_rec.offset;
                ram_wrec.in_use = 1'b1;
                if (r_split) begin
                    ram_wrec.nbytes = 32'(ffha_pkg::HEADER_BYTES) + r_need;
                    ram_wrec.link   = {1'b0, r_spare_idx};
                    newpay          = r_need;
                end else begin
                    ram_wrec.nbytes = r_rec.nbytes;
                    ram_wrec.link   = r_rec.link;
                    newpay          = rec_pay;
                end
                n_res_addr = gaddr;
                n_status   = ffha_pkg::ST_OK;
                if (r_job == ffha_pkg::J_CALLOC) begin
                    n_fill = ffha_pkg::FILL_CLEAR;
                    n_len  = r_need;
                end else if (r_job == ffha_pkg::J_REALLOC && gaddr != r_addr) begin
                    n_fill = ffha_pkg::FILL_COPY;
                    n_len  = (r_oldpay < newpay) ? r_oldpay : newpay;
                end
                n_st = ffha_pkg::S_DONE;
            end
            ffha_pkg::S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = r_res_addr;
                    n_out_status = r_status;
                    n_out_fill   = r_fill;
                    n_out_len    = r_len;
                    n_st         = ffha_pkg::S_IDLE;
                end
            end
            default: begin
                n_st = ffha_pkg::S_INIT;
            end
        endcase

        if (i_cfg_we) begin
            if (i_cfg_index == ffha_pkg::CFG_HEAP_BASE) begin
                n_heap_base = i_cfg_wdata;
            end else begin
                n_heap_bytes = i_cfg_wdata;
            end
            n_st = ffha_pkg::S_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st         <= ffha_pkg::S_INIT;
            r_heap_base  <= '0;
            r_heap_bytes <= ffha_pkg::HEAP_BYTES_RST;
            r_out_valid  <= 1'b0;
            r_job        <= ffha_pkg::J_ALLOC;
            r_mode       <= ffha_pkg::W_FIND;
            r_prev_v     <= 1'b0;
            r_nx_v       <= 1'b0;
            r_split      <= 1'b0;
        end else begin
            r_st         <= n_st;
            r_heap_base  <= n_heap_base;
            r_heap_bytes <= n_heap_bytes;
            r_out_valid  <= n_out_valid;
            r_job        <= n_job;
            r_mode       <= n_mode;
            r_prev_v     <= n_prev_v;
            r_nx_v       <= n_nx_v;
            r_split      <= n_split;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size        <= n_size;
        r_count       <= n_count;
        r_addr        <= n_addr;
        r_tgt_off     <= n_tgt_off;
        r_need        <= n_need;
        r_mul         <= n_mul;
        r_cur         <= n_cur;
        r_prev_idx    <= n_prev_idx;
        r_prev        <= n_prev;
        r_rec_idx     <= n_rec_idx;
        r_rec         <= n_rec;
        r_nx          <= n_nx;
        r_merge_bytes <= n_merge_bytes;
        r_merge_link  <= n_merge_link;
        r_oldpay      <= n_oldpay;
        r_spare_idx   <= n_spare_idx;
        r_res_addr    <= n_res_addr;
        r_status      <= n_status;
        r_fill        <= n_fill;
        r_len         <= n_len;
        r_out_addr    <= n_out_addr;
        r_out_status  <= n_out_status;
        r_out_fill    <= n_out_fill;
        r_out_len     <= n_out_len;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_len, r_out_fill, r_out_status, r_out_addr};

    `FFHA_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second request taken while one is in work")
    `FFHA_ASSERT_SAME(a_spare_not_head, i_clk, i_rst_n, busy_sts.found, busy_sts.idx != '0, "record 0 offered as spare")
    `FFHA_ASSERT_NEXT(a_cfg_rebuild, i_clk, i_rst_n, i_cfg_we, r_st == ffha_pkg::S_INIT, "configuration write did not rebuild the table")
    `FFHA_ASSERT_NEXT(a_done_loads, i_clk, i_rst_n, r_st == ffha_pkg::S_DONE && !i_cfg_we && (!r_out_valid || m_axis_tready), m_axis_tvalid, "response not loaded")

endmodule
